// ===== hdl/hufp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hufp_pkg
// Shared constants, item codes and types for the Huffman table bit packer.
// ----------------------------------------------------------------------------
package hufp_pkg;

  localparam int TABLE_DEPTH   = 256;
  localparam int MAX_CODE_BITS = 8;

  localparam int KIND_W   = 2;
  localparam int SYM_W    = 8;
  localparam int CODE_W   = 8;
  localparam int LEN_W    = 4;
  localparam int CNT_W    = 3;
  localparam int ACC_W    = 15;
  localparam int BYTE_W   = 8;
  localparam int ADDR_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ENTRY_W  = CODE_W + LEN_W;

  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

  localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_CODE_BITS);
  localparam logic [LEN_W-1:0] LEN_BYTE = LEN_W'(BYTE_W);

  // Item after the table read, handed to the packer.
  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic              hit;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } item_t;

endpackage

// ===== hdl/hufp_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hufp_in_if
// Input channel: load, encode and flush words with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hufp_in_if;
  logic                         valid;
  logic                         ready;
  logic [hufp_pkg::KIND_W-1:0]  kind;
  logic [hufp_pkg::SYM_W-1:0]   symbol;
  logic [hufp_pkg::CODE_W-1:0]  code_bits;
  logic [hufp_pkg::LEN_W-1:0]   code_length;

  modport source (output valid, kind, symbol, code_bits, code_length, input ready);
  modport sink   (input valid, kind, symbol, code_bits, code_length, output ready);
endinterface

// ===== hdl/hufp_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hufp_out_if
// Output channel: packed bytes with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hufp_out_if;
  logic                         valid;
  logic                         ready;
  logic [hufp_pkg::BYTE_W-1:0]  out_byte;
  logic [hufp_pkg::LEN_W-1:0]   valid_bits;
  logic                         is_flush;

  modport source (output valid, out_byte, valid_bits, is_flush, input ready);
  modport sink   (input valid, out_byte, valid_bits, is_flush, output ready);
endinterface

// ===== hdl/hufp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hufp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hufp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/hufp_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hufp_packer
// Merges looked-up codes into the bit accumulator and registers output bytes.
// ----------------------------------------------------------------------------
module hufp_packer (
  input  logic              clk,
  input  logic              rst,
  input  hufp_pkg::item_t   item,
  output logic              ready,
  hufp_out_if.source        result
);

  logic [hufp_pkg::ACC_W-1:0]  acc;
  logic [hufp_pkg::CNT_W-1:0]  pcnt;
  logic                        out_valid;
  logic [hufp_pkg::BYTE_W-1:0] out_byte;
  logic [hufp_pkg::LEN_W-1:0]  valid_bits;
  logic                        is_flush;

  logic [hufp_pkg::ACC_W-1:0]  acc_next;
  logic [hufp_pkg::CNT_W-1:0]  pcnt_next;
  logic [hufp_pkg::LEN_W-1:0]  len_eff;
  logic [hufp_pkg::CODE_W:0]   mask;
  logic [hufp_pkg::CODE_W-1:0] code_m;
  logic [hufp_pkg::ACC_W-1:0]  merged;
  logic [hufp_pkg::LEN_W-1:0]  total;
  logic                        emit;
  logic [hufp_pkg::BYTE_W-1:0] byte_val;
  logic [hufp_pkg::LEN_W-1:0]  vb_val;
  logic                        fl_val;
  logic                        fire;

  assign ready = !out_valid || result.ready;
  assign fire  = item.valid && ready;

  always_comb begin
    len_eff   = item.hit ? item.len : '0;
    mask      = ((hufp_pkg::CODE_W+1)'(1) << len_eff) - (hufp_pkg::CODE_W+1)'(1);
    code_m    = item.code & mask[hufp_pkg::CODE_W-1:0];
    merged    = acc | (hufp_pkg::ACC_W'(code_m) << pcnt);
    total     = hufp_pkg::LEN_W'(pcnt) + len_eff;
    acc_next  = acc;
    pcnt_next = pcnt;
    emit      = 1'b0;
    byte_val  = acc[hufp_pkg::BYTE_W-1:0];
    vb_val    = hufp_pkg::LEN_BYTE;
    fl_val    = 1'b0;
    case (item.kind)
      hufp_pkg::KIND_ENCODE: begin
        acc_next  = merged;
        pcnt_next = total[hufp_pkg::CNT_W-1:0];
        if (total >= hufp_pkg::LEN_BYTE) begin
          // full byte leaves, remainder drops down
          emit     = 1'b1;
          byte_val = merged[hufp_pkg::BYTE_W-1:0];
          acc_next = merged >> hufp_pkg::BYTE_W;
        end
      end
      hufp_pkg::KIND_FLUSH: begin
        if (pcnt != '0) begin
          emit   = 1'b1;
          vb_val = hufp_pkg::LEN_W'(pcnt);
          fl_val = 1'b1;
        end
        acc_next  = '0;
        pcnt_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      pcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        acc  <= acc_next;
        pcnt <= pcnt_next;
      end
      if (ready) begin
        out_valid <= fire && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_byte   <= byte_val;
      valid_bits <= vb_val;
      is_flush   <= fl_val;
    end
  end

  assign result.valid      = out_valid;
  assign result.out_byte   = out_byte;
  assign result.valid_bits = valid_bits;
  assign result.is_flush   = is_flush;

endmodule

// ===== hdl/huffman_table_bit_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_table_bit_packer
// Table-driven Huffman encoder packing code bits LSB first into bytes.
// ----------------------------------------------------------------------------
// Pipeline: a word's table RAM read is registered, then its code is merged
//   into the accumulator and the output byte register.
// Throughput: one word per cycle while the output is not stalled; the registered
//   table read and the single shift-merge of the accumulator set this.
// Reset: clears the accumulator, pending count, output valid and all table
//   entry valid bits at once; no clearing pass, words are taken right away.
module huffman_table_bit_packer (
  input  logic        clk,
  input  logic        rst,
  hufp_in_if.sink     item,
  hufp_out_if.source  result
);

  logic [hufp_pkg::TABLE_DEPTH-1:0] entry_valid;
  logic [hufp_pkg::ADDR_W-1:0]      addr;
  logic                             in_range;
  logic                             accept;
  logic                             load_we;
  logic [hufp_pkg::LEN_W-1:0]       len_sat;
  logic [hufp_pkg::ENTRY_W-1:0]     rdata;
  logic                             pk_ready;

  logic                             s1_valid;
  logic [hufp_pkg::KIND_W-1:0]      s1_kind;
  logic                             s1_hit;
  hufp_pkg::item_t                  s1_item;

  assign addr     = item.symbol[hufp_pkg::ADDR_W-1:0];
  assign in_range = {1'b0, item.symbol} < (hufp_pkg::SYM_W+1)'(hufp_pkg::TABLE_DEPTH);
  assign item.ready = !s1_valid || pk_ready;
  assign accept   = item.valid && item.ready;
  assign load_we  = accept && (item.kind == hufp_pkg::KIND_LOAD) && in_range;
  assign len_sat  = (item.code_length > hufp_pkg::LEN_MAX) ? hufp_pkg::LEN_MAX
                                                            : item.code_length;

  hufp_ram #(
    .WIDTH (hufp_pkg::ENTRY_W),
    .DEPTH (hufp_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (load_we),
    .waddr (addr),
    .wdata ({len_sat, item.code_bits}),
    .re    (accept),
    .raddr (addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      s1_valid    <= 1'b0;
    end else begin
      if (load_we) begin
        entry_valid[addr] <= 1'b1;
      end
      if (item.ready) begin
        s1_valid <= accept;
      end
    end
  end

  // never-loaded entries read as length zero
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind <= item.kind;
      s1_hit  <= in_range && entry_valid[addr];
    end
  end

  always_comb begin
    s1_item.valid = s1_valid;
    s1_item.kind  = s1_kind;
    s1_item.hit   = s1_hit;
    s1_item.code  = rdata[hufp_pkg::CODE_W-1:0];
    s1_item.len   = rdata[hufp_pkg::ENTRY_W-1:hufp_pkg::CODE_W];
  end

  hufp_packer u_packer (
    .clk    (clk),
    .rst    (rst),
    .item   (s1_item),
    .ready  (pk_ready),
    .result (result)
  );

endmodule

// ===== hdl/hufp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hufp_checker
// Port-level checks on the packed byte stream of the Huffman bit packer.
// ----------------------------------------------------------------------------
module hufp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [hufp_pkg::BYTE_W-1:0] out_byte,
  input logic [hufp_pkg::LEN_W-1:0]  valid_bits,
  input logic                        is_flush
);

  // a stalled byte holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(valid_bits)
      && $stable(is_flush))
    else $error("stalled output word changed");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_flush == (valid_bits != hufp_pkg::LEN_BYTE)))
    else $error("flush marker disagrees with bit count");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (valid_bits != '0) && (valid_bits <= hufp_pkg::LEN_BYTE))
    else $error("bit count out of range");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_flush |-> ((out_byte >> valid_bits) == '0))
    else $error("flushed byte not zero padded");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

bind huffman_table_bit_packer hufp_checker u_hufp_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (result.valid),
  .out_ready  (result.ready),
  .out_byte   (result.out_byte),
  .valid_bits (result.valid_bits),
  .is_flush   (result.is_flush)
);
